// ===== rtl/core/icmp_echo_tracker_defines.svh =====
// Assertion macros used by the echo tracker checker.
`ifndef ICMP_ECHO_TRACKER_DEFINES_SVH
`define ICMP_ECHO_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IET_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/iet_pkg.sv =====
// Types, constants and codes of the ICMP echo tracker.
package iet_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned TIME_WIDTH_DEF  = 32;
  localparam int unsigned CNT_W           = 8;
  localparam int unsigned RTT_W           = 32;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [7:0]  ICMP_TYPE_ECHO_REQ = 8'd8;
  localparam logic [7:0]  ICMP_TYPE_ECHO_REP = 8'd0;
  localparam logic [7:0]  ICMP_CODE_ECHO     = 8'd0;
  localparam logic [15:0] ECHO_ID_RST        = 16'h0000;
  localparam logic [7:0]  PKT_LIMIT_RST      = 8'd12;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_REPLY = 2'd2,
    KIND_RSVD  = 2'd3
  } in_kind_e;

  typedef enum logic [1:0] {
    RES_REQUEST  = 2'd0,
    RES_MATCH    = 2'd1,
    RES_OVERFLOW = 2'd2,
    RES_FOREIGN  = 2'd3
  } res_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECHO_ID   = 1'b0,
    CFG_PKT_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_type;
    logic [15:0] msg_ident;
    logic [15:0] msg_seq;
  } iet_in_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       out_type;
    logic [15:0]      out_ident;
    logic [15:0]      out_seq;
    logic [15:0]      out_checksum;
    logic [RTT_W-1:0] round_trip;
    logic [CNT_W-1:0] sent_total;
    logic [CNT_W-1:0] received_total;
  } iet_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } iet_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_result;
    logic out_free;
  } iet_sts_t;

endpackage

// ===== rtl/core/iet_ctrl.sv =====
// Controller FSM of the echo tracker: capture, then execute and commit.
module iet_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  iet_pkg::iet_sts_t sts_i,
  output iet_pkg::iet_cmd_t cmd_o
);
  import iet_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold while the output register is still occupied
        if (!sts_i.has_result || sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/iet_dp.sv =====
// Datapath of the echo tracker: config, counters, stamp table, checksum, output register.
module iet_dp #(
  parameter int unsigned TABLE_DEPTH = iet_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = iet_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  iet_pkg::iet_in_t                  in_data_i,
  input  logic                              cfg_we_i,
  input  logic [iet_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [iet_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  iet_pkg::iet_cmd_t                 cmd_i,
  output iet_pkg::iet_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output iet_pkg::iet_out_t                 out_data_o
);
  import iet_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [15:0] DEPTH_16 = 16'(TABLE_DEPTH);
  localparam logic [15:0] CHK_WORD0 = {ICMP_TYPE_ECHO_REQ, ICMP_CODE_ECHO};

  logic [15:0]           echo_id_q;
  logic [CNT_W-1:0]      limit_q;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [CNT_W-1:0]      sent_q, sent_d;
  logic [CNT_W-1:0]      recv_q, recv_d;
  iet_in_t               item_q;
  iet_out_t              out_q, res;
  logic                  out_valid_q;
  logic                  has_res;
  logic                  mem_we;
  logic                  send_ok;
  logic [17:0]           chk_sum;
  logic [16:0]           chk_fold1;
  logic [15:0]           chk_fold2;
  logic [TIME_WIDTH-1:0] rtt_full;

  logic [TIME_WIDTH-1:0] stamp_mem [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] stamp_rd_q;

  // stamp table: write on committed send, read on capture
  always_ff @(posedge clk_i) begin
    if (mem_we && cmd_i.commit) begin
      stamp_mem[IDX_W'(sent_q)] <= time_q;
    end
    if (cmd_i.capture) begin
      stamp_rd_q <= stamp_mem[IDX_W'(in_data_i.msg_seq)];
    end
  end

  assign send_ok = (sent_q < limit_q) && ({8'd0, sent_q} < DEPTH_16);

  // internet checksum of {type,code}, id, seq with end-around carry
  assign chk_sum   = 18'(CHK_WORD0) + 18'(echo_id_q) + 18'(sent_q);
  assign chk_fold1 = 17'(chk_sum[15:0]) + 17'(chk_sum[17:16]);
  assign chk_fold2 = chk_fold1[15:0] + 16'(chk_fold1[16]);

  assign rtt_full = time_q - stamp_rd_q;

  always_comb begin
    has_res            = 1'b0;
    mem_we             = 1'b0;
    time_d             = time_q;
    sent_d             = sent_q;
    recv_d             = recv_q;
    res                = '0;
    res.out_seq        = item_q.msg_seq;
    res.sent_total     = sent_q;
    res.received_total = recv_q;
    unique case (in_kind_e'(item_q.kind))
      KIND_TICK: begin
        time_d = time_q + TIME_WIDTH'(1);
      end
      KIND_SEND: begin
        if (send_ok) begin
          has_res          = 1'b1;
          mem_we           = 1'b1;
          sent_d           = sent_q + CNT_W'(1);
          res.result_kind  = RES_REQUEST;
          res.out_type     = ICMP_TYPE_ECHO_REQ;
          res.out_ident    = echo_id_q;
          res.out_seq      = 16'(sent_q);
          res.out_checksum = ~chk_fold2;
          res.sent_total   = sent_d;
        end
      end
      KIND_REPLY: begin
        if (recv_q < limit_q) begin
          has_res = 1'b1;
          if (item_q.msg_type != ICMP_TYPE_ECHO_REP || item_q.msg_ident != echo_id_q) begin
            res.result_kind = RES_FOREIGN;
          end else if (item_q.msg_seq >= DEPTH_16) begin
            res.result_kind = RES_OVERFLOW;
          end else begin
            recv_d             = recv_q + CNT_W'(1);
            res.result_kind    = RES_MATCH;
            res.round_trip     = RTT_W'(rtt_full);
            res.received_total = recv_d;
          end
        end
      end
      KIND_RSVD: begin
      end
      default: begin
      end
    endcase
  end

  assign sts_o.has_result = has_res;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_id_q   <= ECHO_ID_RST;
      limit_q     <= PKT_LIMIT_RST;
      time_q      <= '0;
      sent_q      <= '0;
      recv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ECHO_ID:   echo_id_q <= cfg_data_i;
          CFG_PKT_LIMIT: limit_q   <= cfg_data_i[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.commit) begin
        time_q <= time_d;
        sent_q <= sent_d;
        recv_q <= recv_d;
      end
      if (cmd_i.commit && has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.commit && has_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/icmp_echo_tracker.sv =====
// Each input transaction is captured in the idle state, then executed and committed in the execute
// state (held while a result waits for the occupied output register); a new one is not accepted
// until the last has committed, as the registered stamp-table read must complete before that step.
// Reset (async, active low): time, counters and output valid clear, echo_id 0, limit 12;
// the stamp table is not cleared.
module icmp_echo_tracker #(
  parameter int unsigned TABLE_DEPTH = iet_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = iet_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  iet_pkg::iet_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output iet_pkg::iet_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [iet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [iet_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import iet_pkg::*;

  iet_cmd_t cmd;
  iet_sts_t sts;

  assign cfg_ready_o = 1'b1;

  iet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iet_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/iet_checker.sv =====
// Port-level checks of the echo tracker and their binding.
`include "icmp_echo_tracker_defines.svh"

module iet_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input iet_pkg::iet_out_t out_data_o
);
  import iet_pkg::*;

  `IET_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  `IET_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
    !in_ready_o, "transaction accepted during execute cycle")

  `IET_ASSERT_NOW(a_request_fields, clk_i, rst_ni,
    out_valid_o && out_data_o.result_kind == RES_REQUEST,
    out_data_o.out_type == ICMP_TYPE_ECHO_REQ && out_data_o.round_trip == '0,
    "request header malformed")

  `IET_ASSERT_NOW(a_reply_fields, clk_i, rst_ni,
    out_valid_o && out_data_o.result_kind != RES_REQUEST,
    out_data_o.out_type == 8'd0 && out_data_o.out_ident == 16'd0 &&
    out_data_o.out_checksum == 16'd0, "reply result carries header fields")

endmodule

bind icmp_echo_tracker iet_checker u_iet_checker (.*);

// ===== sim/iet_scoreboard_pkg.sv =====
// Scoreboard for the ICMP echo tracker: predicts echo results and checks the block's output.
`timescale 1ns / 100ps
package iet_scoreboard_pkg;
  import iet_pkg::*;

  class echo_scoreboard;
    logic [15:0] echo_id;
    logic [7:0]  pkt_limit;
    logic [31:0] tick_count;
    logic [7:0]  sent_cnt;
    logic [7:0]  recv_cnt;
    logic [31:0] send_stamp [TABLE_DEPTH_DEF];
    bit          stamped [TABLE_DEPTH_DEF];
    bit          awaiting [TABLE_DEPTH_DEF];
    iet_out_t    echo_results_q [$];
    int          mismatches;

    function new();
      echo_id    = ECHO_ID_RST;
      pkt_limit  = PKT_LIMIT_RST;
      tick_count = '0;
      sent_cnt   = '0;
      recv_cnt   = '0;
      mismatches = 0;
      foreach (stamped[i]) begin
        stamped[i]    = 1'b0;
        awaiting[i]   = 1'b0;
        send_stamp[i] = '0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ECHO_ID: begin
          echo_id = data;
        end
        CFG_PKT_LIMIT: begin
          pkt_limit = data[7:0];
        end
        default: ;
      endcase
    endfunction

    // one's complement of the end-around-carry sum of type/code, id and sequence
    function logic [15:0] header_checksum(logic [15:0] sq);
      logic [17:0] sum;
      sum = {2'b00, ICMP_TYPE_ECHO_REQ, ICMP_CODE_ECHO} + echo_id + sq;
      sum = {2'b00, sum[15:0]} + sum[17:16];
      sum = {2'b00, sum[15:0]} + sum[17:16];
      return ~sum[15:0];
    endfunction

    function void note_input(iet_in_t it);
      iet_out_t res;
      res = '0;
      case (it.kind)
        KIND_TICK: begin
          tick_count = tick_count + 32'd1;
        end
        KIND_SEND: begin
          if (sent_cnt < pkt_limit && sent_cnt < TABLE_DEPTH_DEF) begin
            send_stamp[sent_cnt] = tick_count;
            stamped[sent_cnt]    = 1'b1;
            awaiting[sent_cnt]   = 1'b1;
            res.result_kind      = RES_REQUEST;
            res.out_type         = ICMP_TYPE_ECHO_REQ;
            res.out_ident        = echo_id;
            res.out_seq          = {8'h00, sent_cnt};
            res.out_checksum     = header_checksum({8'h00, sent_cnt});
            sent_cnt             = sent_cnt + 8'd1;
            res.sent_total       = sent_cnt;
            res.received_total   = recv_cnt;
            echo_results_q.push_back(res);
          end
        end
        KIND_REPLY: begin
          if (recv_cnt < pkt_limit) begin
            res.out_seq = it.msg_seq;
            if (it.msg_type != ICMP_TYPE_ECHO_REP || it.msg_ident != echo_id) begin
              res.result_kind = RES_FOREIGN;
            end else if (it.msg_seq >= TABLE_DEPTH_DEF) begin
              res.result_kind = RES_OVERFLOW;
            end else begin
              awaiting[it.msg_seq] = 1'b0;
              res.result_kind      = RES_MATCH;
              res.round_trip       = tick_count - send_stamp[it.msg_seq];
              recv_cnt             = recv_cnt + 8'd1;
            end
            res.sent_total     = sent_cnt;
            res.received_total = recv_cnt;
            echo_results_q.push_back(res);
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t mismatch: %s", $time, msg);
      end
    endfunction

    function void check_result(iet_out_t got);
      iet_out_t want;
      if (echo_results_q.size() == 0) begin
        flag($sformatf("unexpected transaction %h", got));
        return;
      end
      want = echo_results_q.pop_front();
      if (got.result_kind !== want.result_kind)
        flag($sformatf("result_kind exp %0d got %0d", want.result_kind, got.result_kind));
      if (got.out_type !== want.out_type)
        flag($sformatf("out_type exp %h got %h", want.out_type, got.out_type));
      if (got.out_ident !== want.out_ident)
        flag($sformatf("out_ident exp %h got %h", want.out_ident, got.out_ident));
      if (got.out_seq !== want.out_seq)
        flag($sformatf("out_seq exp %h got %h", want.out_seq, got.out_seq));
      if (got.out_checksum !== want.out_checksum)
        flag($sformatf("out_checksum exp %h got %h", want.out_checksum, got.out_checksum));
      if (got.round_trip !== want.round_trip)
        flag($sformatf("round_trip exp %h got %h", want.round_trip, got.round_trip));
      if (got.sent_total !== want.sent_total)
        flag($sformatf("sent_total exp %0d got %0d", want.sent_total, got.sent_total));
      if (got.received_total !== want.received_total)
        flag($sformatf("received_total exp %0d got %0d", want.received_total,
                       got.received_total));
    endfunction
  endclass

endpackage

// ===== sim/tb_icmp_echo_tracker.sv =====
// Testbench top for the ICMP echo tracker: directed and random echo traffic with random stalls.
`timescale 1ns / 100ps
module tb_icmp_echo_tracker;
  import iet_pkg::*;
  import iet_scoreboard_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int          CYCLE_LIMIT = 1_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  iet_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  iet_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  echo_scoreboard sb;
  int             cycles     = 0;
  int             stall_left = 0;
  bit             tx_quiet   = 1'b0;
  bit             rx_quiet   = 1'b0;

  icmp_echo_tracker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(1'b0);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ($urandom_range(0, 249) == 0) rx_quiet = !rx_quiet;
    end
  end

  function automatic iet_in_t echo_msg(in_kind_e k, logic [7:0] mtype, logic [15:0] ident,
                                       logic [15:0] sq);
    iet_in_t it;
    it.kind      = k;
    it.msg_type  = mtype;
    it.msg_ident = ident;
    it.msg_seq   = sq;
    return it;
  endfunction

  task automatic drive_item(iet_in_t it);
    int gap;
    gap = pick_gap(tx_quiet);
    // a matching reply may only name a sequence whose stamp has been written
    if (it.kind == KIND_REPLY && it.msg_type == ICMP_TYPE_ECHO_REP &&
        it.msg_ident == sb.echo_id && it.msg_seq < DEPTH && !sb.stamped[it.msg_seq]) begin
      if (sb.sent_cnt != 0) it.msg_seq = 16'($urandom_range(0, sb.sent_cnt - 1));
      else it.msg_seq = 16'($urandom_range(DEPTH, 16'hffff));
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.echo_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] id, logic [7:0] limit);
    logic [15:0] limit_word;
    limit_word = {8'($urandom), limit};
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_idx   <= CFG_ECHO_ID;
    cfg_data  <= id;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(CFG_ECHO_ID, id);
    cfg_idx  <= CFG_PKT_LIMIT;
    cfg_data <= limit_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(CFG_PKT_LIMIT, limit_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic iet_in_t random_item();
    iet_in_t it;
    int      r;
    it.msg_type  = 8'($urandom_range(0, 255));
    it.msg_ident = 16'($urandom_range(0, 16'hffff));
    it.msg_seq   = 16'($urandom_range(0, 16'hffff));
    r = $urandom_range(0, 99);
    if (r < 35) it.kind = KIND_TICK;
    else if (r < 47) it.kind = KIND_SEND;
    else if (r < 92) it.kind = KIND_REPLY;
    else it.kind = KIND_RSVD;
    if (it.kind == KIND_REPLY) begin
      r = $urandom_range(0, 99);
      // keep the receive count below the limit so replies keep producing results
      if (r < 60 && sb.sent_cnt != 0 && sb.recv_cnt + 4 < sb.pkt_limit) begin
        it.msg_type  = ICMP_TYPE_ECHO_REP;
        it.msg_ident = sb.echo_id;
        it.msg_seq   = 16'($urandom_range(0, sb.sent_cnt - 1));
      end else if (r < 75) begin
        it.msg_type = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 1) it.msg_ident = sb.echo_id;
      end else if (r < 88) begin
        it.msg_type = ICMP_TYPE_ECHO_REP;
      end else begin
        it.msg_type  = ICMP_TYPE_ECHO_REP;
        it.msg_ident = sb.echo_id;
        it.msg_seq   = 16'($urandom_range(DEPTH, 16'hffff));
      end
    end
    return it;
  endfunction

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) == 0) tx_quiet = !tx_quiet;
      drive_item(random_item());
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_item(echo_msg(KIND_RSVD, 8'hff, 16'hffff, 16'hffff));
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, ECHO_ID_RST, 16'hffff));
    drive_item(echo_msg(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    drive_item(echo_msg(KIND_SEND, 8'h00, 16'h0000, 16'h0000));
    drive_item(echo_msg(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    drive_item(echo_msg(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    drive_item(echo_msg(KIND_SEND, 8'h00, 16'h0000, 16'h0000));
    // second reply to the same entry still matches
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, ECHO_ID_RST, 16'd0));
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, ECHO_ID_RST, 16'd0));
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REQ, ECHO_ID_RST, 16'd1));
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, 16'hffff, 16'd1));
    drive_item(echo_msg(KIND_REPLY, 8'hff, 16'hffff, 16'd0));
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, ECHO_ID_RST, 16'(DEPTH)));
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, ECHO_ID_RST, 16'd1));
    drive_item(echo_msg(KIND_TICK, 8'hff, 16'hffff, 16'hffff));
    drive_item(echo_msg(KIND_RSVD, 8'h00, 16'h0000, 16'h0000));
    // last send runs into the send limit
    repeat (11) drive_item(echo_msg(KIND_SEND, 8'hff, 16'hffff, 16'hffff));

    // receive limit one above the count: one match, then replies are dropped
    configure(16'h0000, sb.recv_cnt + 8'd1);
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, 16'h0000, 16'd3));
    drive_item(echo_msg(KIND_REPLY, ICMP_TYPE_ECHO_REP, 16'h0000, 16'd4));
    drive_item(echo_msg(KIND_REPLY, 8'h08, 16'h1234, 16'd4));
    run_random(20);

    configure(16'hffff, 8'd1);
    run_random(25);
    configure(16'($urandom), 8'd0);
    run_random(25);
    configure(16'hffff, 8'd128);
    run_random(450);
    configure(16'($urandom), 8'd200);
    run_random(550);
    configure(16'($urandom), 8'd255);
    run_random(650);

    wait_idle();
    if (sb.mismatches == 0 && sb.echo_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/iet_pkg.sv
rtl/core/iet_ctrl.sv
rtl/core/iet_dp.sv
rtl/core/icmp_echo_tracker.sv
rtl/core/iet_checker.sv
sim/iet_scoreboard_pkg.sv
sim/tb_icmp_echo_tracker.sv
